// ===== src/smss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smss_pkg
// shared types, sizes and helpers for the sorted matrix staircase search
// ----------------------------------------------------------------------------
package smss_pkg;

    // store geometry
    localparam int MAX_ROWS   = 16;
    localparam int MAX_COLS   = 16;
    localparam int DATA_WIDTH = 32;

    // fixed field widths
    localparam int VAL_W   = 32;
    localparam int IDX_W   = 4;
    localparam int MOVE_W  = 6;
    localparam int CFG_W   = 5;
    localparam int CFG_IDX_W = 2;

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int MEM_DEPTH = 2 ** ADDR_W;
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);
    localparam int CCNT_W = $clog2(MAX_COLS + 1);
    localparam int CMP_W  = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;

    localparam logic [MOVE_W-1:0] MOVE_MAX = {MOVE_W{1'b1}};

    // function codes
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED = 2'd1;

    typedef logic [DATA_WIDTH-1:0] elem_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [RCNT_W-1:0]     rcnt_t;
    typedef logic [CCNT_W-1:0]     ccnt_t;

    typedef struct packed {
        logic                     func;
        logic [IDX_W-1:0]         row_index;
        logic [IDX_W-1:0]         col_index;
        logic signed [VAL_W-1:0]  elem_value;
        logic signed [VAL_W-1:0]  target_value;
    } in_item_t;

    typedef struct packed {
        logic              found;
        logic [MOVE_W-1:0] move_count;
    } out_item_t;

    // one access to the matrix memory
    typedef struct packed {
        logic  wr_en;
        logic  rd_en;
        addr_t addr;
        elem_t wdata;
    } mem_req_t;

    // keep the low bits of a signed value, sign extending if the store is wider
    function automatic elem_t to_elem(input logic signed [VAL_W-1:0] v);
        logic signed [CMP_W-1:0] ext;
        begin
            ext = CMP_W'(v);
            return ext[DATA_WIDTH-1:0];
        end
    endfunction

    // address of row r, column c-1 (c points one past the current column)
    function automatic addr_t walk_addr(input rcnt_t r, input ccnt_t c);
        ccnt_t cm1;
        begin
            cm1 = c - 1'b1;
            return {r[ROW_W-1:0], cm1[COL_W-1:0]};
        end
    endfunction

endpackage

// ===== src/sorted_matrix_staircase_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_matrix_staircase_search
// staircase search over a row and column sorted matrix held in block memory
// ----------------------------------------------------------------------------
// load item: no result; loads can be taken every cycle while no search is in progress
// search item: the result is valid once the walk over k positions ends, k = positions visited
//   (at most rows_used + cols_used - 1), one memory read per cycle of the walk
// a new item is taken once the walker has handed its result to the output reg,
//   so back to back searches do not overlap
// reset (aresetn, synchronous, active low): rows_used and cols_used to 16,
//   handshakes idle; the matrix memory is not cleared
module sorted_matrix_staircase_search (
    input  logic                          aclk,
    input  logic                          aresetn,
    // item input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  smss_pkg::in_item_t            s_data,
    // result output
    output logic                          m_valid,
    input  logic                          m_ready,
    output smss_pkg::out_item_t           m_data,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [smss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [smss_pkg::CFG_W-1:0]     cfg_data
);
    import smss_pkg::*;

    // configuration registers
    logic [CFG_W-1:0] rows_used_reg;
    logic [CFG_W-1:0] cols_used_reg;

    // used area clamped to the store size
    rcnt_t nrows;
    ccnt_t ncols;

    // walker to memory
    mem_req_t mem_req;
    elem_t    mem_rd_data;

    // walker result and output register
    logic      res_valid;
    logic      res_ready;
    out_item_t res;
    logic      m_valid_reg;
    out_item_t m_data_reg;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_used_reg <= CFG_W'(16);
            cols_used_reg <= CFG_W'(16);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_ROWS_USED: rows_used_reg <= cfg_data;
                CFG_COLS_USED: cols_used_reg <= cfg_data;
                default: begin
                    // unknown register index, write dropped
                end
            endcase
        end
    end

    // oversize settings saturate to the store bounds
    assign nrows = (32'(rows_used_reg) > MAX_ROWS) ? RCNT_W'(MAX_ROWS)
                                                    : RCNT_W'(rows_used_reg);
    assign ncols = (32'(cols_used_reg) > MAX_COLS) ? CCNT_W'(MAX_COLS)
                                                    : CCNT_W'(cols_used_reg);

    smss_matrix_ram u_ram (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    smss_walker u_walker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (s_valid),
        .item_ready  (s_ready),
        .item        (s_data),
        .nrows       (nrows),
        .ncols       (ncols),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // output register: the walker hands over when it is empty or draining
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_valid && res_ready) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== src/smss_matrix_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smss_matrix_ram
// single port matrix store, registered read data
// ----------------------------------------------------------------------------
module smss_matrix_ram (
    input  logic              aclk,
    input  smss_pkg::mem_req_t req,
    output smss_pkg::elem_t   rd_data
);
    import smss_pkg::*;

    elem_t mem [MEM_DEPTH];
    elem_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/smss_walker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smss_walker
// item decode, load writes and the staircase walk over the matrix memory
// ----------------------------------------------------------------------------
module smss_walker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    output logic                item_ready,
    input  smss_pkg::in_item_t  item,
    input  smss_pkg::rcnt_t     nrows,
    input  smss_pkg::ccnt_t     ncols,
    output smss_pkg::mem_req_t  mem_req,
    input  smss_pkg::elem_t     mem_rd_data,
    output logic                res_valid,
    input  logic                res_ready,
    output smss_pkg::out_item_t res
);
    import smss_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    rcnt_t                   r_reg, r_next;
    ccnt_t                   c_reg, c_next;
    logic [MOVE_W-1:0]       moves_reg, moves_next;
    logic                    found_reg, found_next;
    logic signed [VAL_W-1:0] target_reg, target_next;

    logic                    accept;
    logic                    load_in_range;
    logic                    start_in_range;
    logic                    step_in_range;
    logic signed [CMP_W-1:0] elem_ext;
    logic signed [CMP_W-1:0] tgt_ext;
    rcnt_t                   r_step;
    ccnt_t                   c_step;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;

    assign load_in_range = (32'(item.row_index) < MAX_ROWS) &&
                           (32'(item.col_index) < MAX_COLS);
    assign start_in_range = (nrows != '0) && (ncols != '0);

    assign elem_ext = CMP_W'($signed(mem_rd_data));
    assign tgt_ext  = CMP_W'(target_reg);

    // down when the element is below the target, left otherwise
    assign r_step = (elem_ext < tgt_ext) ? r_reg + 1'b1 : r_reg;
    assign c_step = (elem_ext < tgt_ext) ? c_reg : c_reg - 1'b1;
    assign step_in_range = (r_step < nrows) && (c_step != '0);

    always_comb begin
        state_next  = state_reg;
        r_next      = r_reg;
        c_next      = c_reg;
        moves_next  = moves_reg;
        found_next  = found_reg;
        target_next = target_reg;
        mem_req     = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (item.func == FUNC_LOAD) begin
                        mem_req.wr_en = load_in_range;
                        mem_req.addr  = {ROW_W'(item.row_index), COL_W'(item.col_index)};
                        mem_req.wdata = to_elem(item.elem_value);
                    end else begin
                        target_next = item.target_value;
                        r_next      = '0;
                        c_next      = ncols;
                        moves_next  = '0;
                        found_next  = 1'b0;
                        if (start_in_range) begin
                            mem_req.rd_en = 1'b1;
                            mem_req.addr  = walk_addr('0, ncols);
                            state_next    = ST_CMP;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_CMP: begin
                if (elem_ext == tgt_ext) begin
                    found_next = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    r_next = r_step;
                    c_next = c_step;
                    if (moves_reg != MOVE_MAX) begin
                        moves_next = moves_reg + 1'b1;
                    end
                    if (step_in_range) begin
                        // read of the next position overlaps this compare
                        mem_req.rd_en = 1'b1;
                        mem_req.addr  = walk_addr(r_step, c_step);
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        r_reg      <= r_next;
        c_reg      <= c_next;
        moves_reg  <= moves_next;
        found_reg  <= found_next;
        target_reg <= target_next;
    end

    assign res_valid      = (state_reg == ST_DONE);
    assign res.found      = found_reg;
    assign res.move_count = moves_reg;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// loads sorted matrices into the staircase search block, walks them with
// search items under many row and column settings, and checks every found
// flag and move count against a walk predicted here from its own copy of the
// matrix and geometry
// ----------------------------------------------------------------------------
module testbench;
    import smss_pkg::*;

    // no handshake for this many cycles means the block has hung
    localparam int IDLE_LIMIT    = 2000;
    // longest search is rows + cols - 1 positions
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 120;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_ROWS_USED;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // predictor state: matrix contents and geometry as the block should hold them
    logic signed [DATA_WIDTH-1:0] matrix_copy [MAX_ROWS][MAX_COLS];
    logic [CFG_W-1:0]             rows_setting = CFG_W'(16);
    logic [CFG_W-1:0]             cols_setting = CFG_W'(16);

    // walk results still owed by the block, oldest first
    out_item_t pending_walks [$];

    int mismatch_count = 0;
    int items_sent     = 0;
    // burst flags turn idling off on one side for a whole phase
    bit sender_burst   = 1'b0;
    bit sink_burst     = 1'b0;

    sorted_matrix_staircase_search DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // settings above the store size saturate to it
    function automatic int used_rows();
        return (rows_setting > MAX_ROWS) ? MAX_ROWS : int'(rows_setting);
    endfunction

    function automatic int used_cols();
        return (cols_setting > MAX_COLS) ? MAX_COLS : int'(cols_setting);
    endfunction

    // start at the top-right corner, go down when the element is small,
    // left when it is large, stop on a match or when leaving the area
    function automatic out_item_t staircase_walk(input logic signed [VAL_W-1:0] target);
        out_item_t                    res;
        int                           nrows;
        int                           r;
        int                           c;
        logic signed [DATA_WIDTH-1:0] elem;
        nrows = used_rows();
        c     = used_cols();
        r     = 0;
        res   = '0;
        while (!res.found && r < nrows && c > 0) begin
            elem = matrix_copy[r][c-1];
            if (elem == target) begin
                res.found = 1'b1;
            end else begin
                if (elem < target) begin
                    r++;
                end else begin
                    c--;
                end
                if (res.move_count != MOVE_MAX) begin
                    res.move_count = res.move_count + 1'b1;
                end
            end
        end
        return res;
    endfunction

    // called once the block has taken the item
    function automatic void apply_item(input in_item_t item);
        if (item.func == FUNC_SEARCH) begin
            pending_walks.push_back(staircase_walk(item.target_value));
        end else begin
            matrix_copy[item.row_index][item.col_index] = item.elem_value[DATA_WIDTH-1:0];
        end
    endfunction

    // ------------------------------------------------------------------------
    // item construction; the fields an item does not use get random bits
    // ------------------------------------------------------------------------

    function automatic in_item_t make_load(input int r, input int c,
                                           input logic [VAL_W-1:0] value);
        in_item_t item;
        item.func         = FUNC_LOAD;
        item.row_index    = IDX_W'(r);
        item.col_index    = IDX_W'(c);
        item.elem_value   = value;
        item.target_value = $urandom;
        return item;
    endfunction

    function automatic in_item_t make_search(input logic [VAL_W-1:0] target);
        in_item_t item;
        item.func         = FUNC_SEARCH;
        item.row_index    = IDX_W'($urandom_range(0, 15));
        item.col_index    = IDX_W'($urandom_range(0, 15));
        item.elem_value   = $urandom;
        item.target_value = target;
        return item;
    endfunction

    // mostly values that sit in the used area, some neighbors and strays
    function automatic logic [VAL_W-1:0] pick_target();
        int                 nr;
        int                 nc;
        int                 kind;
        logic [VAL_W-1:0]   hit;
        nr   = used_rows();
        nc   = used_cols();
        kind = $urandom_range(0, 19);
        if (nr == 0 || nc == 0 || kind >= 17) begin
            return $urandom;
        end
        hit = matrix_copy[$urandom_range(0, nr - 1)][$urandom_range(0, nc - 1)];
        if (kind < 10) begin
            return hit;
        end else if (kind < 13) begin
            return hit + 1'b1;
        end else if (kind < 16) begin
            return hit - 1'b1;
        end
        return {1'b1, {(VAL_W-1){1'b0}}};
    endfunction

    function automatic int draw_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, 14);
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // valid is only dropped when a gap follows, so back to back items keep it high
    task automatic send_item(input in_item_t item);
        int gap;
        gap = draw_wait(sender_burst);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        apply_item(item);
        items_sent++;
    endtask

    // stop sending, wait for every owed walk, then let a load or walk in
    // flight finish
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_walks.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (index == CFG_ROWS_USED) begin
            rows_setting = value;
        end else begin
            cols_setting = value;
        end
    endtask

    // geometry only changes with the block idle
    task automatic set_geometry(input int rows, input int cols);
        drain_results();
        write_reg(CFG_ROWS_USED, CFG_W'(rows));
        write_reg(CFG_COLS_USED, CFG_W'(cols));
        cfg_valid <= 1'b0;
    endtask

    // each element is at least its upper and left neighbors plus a random step,
    // so rows and columns come out ascending; duplicates happen when steps are 0
    task automatic fill_sorted(input int nr, input int nc, input longint first_value,
                               input int unsigned max_step, input bit span_full);
        longint grid [MAX_ROWS][MAX_COLS];
        longint value;
        for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
                if (r == 0 && c == 0) begin
                    value = first_value;
                end else begin
                    if (r == 0) begin
                        value = grid[r][c-1];
                    end else if (c == 0) begin
                        value = grid[r-1][c];
                    end else begin
                        value = (grid[r-1][c] > grid[r][c-1]) ? grid[r-1][c] : grid[r][c-1];
                    end
                    value = value + longint'($urandom_range(0, max_step));
                end
                if (value > 64'sd2147483647) begin
                    value = 64'sd2147483647;
                end
                if (span_full && r == nr - 1 && c == nc - 1) begin
                    value = 64'sd2147483647;
                end
                grid[r][c] = value;
                send_item(make_load(r, c, value[VAL_W-1:0]));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    initial begin : result_sink
        out_item_t want;
        int        stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = draw_wait(sink_burst);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_walks.size() == 0) begin
                report_mismatch("result with no search waiting");
            end else begin
                want = pending_walks.pop_front();
                if (m_data.found !== want.found) begin
                    report_mismatch($sformatf("found %0b, expected %0b",
                                              m_data.found, want.found));
                end
                if (m_data.move_count !== want.move_count) begin
                    report_mismatch($sformatf("move_count %0d, expected %0d",
                                              m_data.move_count, want.move_count));
                end
            end
        end
    end

    // only counts cycles in which no channel moves anything
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // whole store written once, so no later walk can touch an unwritten entry;
    // searches run at the 16 by 16 geometry left by reset
    task automatic test_reset_geometry();
        fill_sorted(MAX_ROWS, MAX_COLS, -64'sd2147483648, 32'h1000_0000, 1'b1);
        send_item(make_search(32'h8000_0000));
        send_item(make_search(32'h7fff_ffff));
        send_item(make_search(matrix_copy[0][MAX_COLS-1]));
        send_item(make_search(matrix_copy[MAX_ROWS-1][0]));
        send_item(make_search(matrix_copy[7][8]));
        send_item(make_search(matrix_copy[9][3] + 1'b1));
    endtask

    // empty areas, saturating settings, single row and single column
    task automatic test_area_edges();
        set_geometry(0, 16);
        send_item(make_search(matrix_copy[0][0]));
        set_geometry(16, 0);
        send_item(make_search(matrix_copy[0][0]));
        set_geometry(0, 0);
        send_item(make_search(32'h0000_0000));
        set_geometry(31, 31);
        send_item(make_search(32'h8000_0000));
        send_item(make_search(32'h7fff_ffff));
        set_geometry(1, 1);
        send_item(make_search(matrix_copy[0][0]));
        send_item(make_search(matrix_copy[0][0] + 1'b1));
        set_geometry(1, 16);
        send_item(make_search(matrix_copy[0][3]));
        set_geometry(16, 1);
        send_item(make_search(matrix_copy[12][0]));
        set_geometry(17, 5);
        send_item(make_search(matrix_copy[15][2]));
    endtask

    // single loads give no result; three of the new values must be found afterwards
    task automatic test_single_loads();
        set_geometry(2, 2);
        send_item(make_load(0, 0, 32'h8000_0000));
        send_item(make_load(0, 1, 32'h2aaa_aaaa));
        send_item(make_load(1, 0, 32'h5555_5555));
        send_item(make_load(1, 1, 32'h7fff_ffff));
        send_item(make_search(32'h2aaa_aaaa));
        send_item(make_search(32'h5555_5555));
        send_item(make_search(32'h8000_0000));
        send_item(make_search(32'h0000_0000));
    endtask

    // mostly small areas, sometimes empty, full or oversized
    function automatic int pick_dimension();
        int kind;
        kind = $urandom_range(0, 15);
        if (kind == 0) begin
            return 0;
        end else if (kind == 1) begin
            return $urandom_range(17, 31);
        end else if (kind == 2) begin
            return 16;
        end
        return $urandom_range(1, 6);
    endfunction

    // each phase: new geometry, fresh sorted contents for the used area,
    // then searches with a few stray loads that break the ordering
    task automatic test_random_walks();
        int start_count;
        int searches;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            set_geometry(pick_dimension(), pick_dimension());
            sender_burst = ($urandom_range(0, 3) == 0);
            sink_burst   = ($urandom_range(0, 3) == 0);
            fill_sorted(used_rows(), used_cols(), longint'($signed($urandom)),
                        32'd1 << $urandom_range(0, 24), 1'b0);
            searches = $urandom_range(6, 16);
            repeat (searches) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_item(make_load($urandom_range(0, 15), $urandom_range(0, 15),
                                        $urandom));
                end else begin
                    send_item(make_search(pick_target()));
                end
            end
        end
        sender_burst = 1'b0;
        sink_burst   = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_geometry();
        test_area_edges();
        test_single_loads();
        test_random_walks();
        drain_results();
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sorted_matrix_staircase_search.f =====
src/smss_pkg.sv
src/smss_matrix_ram.sv
src/smss_walker.sv
src/sorted_matrix_staircase_search.sv
tb/sv/testbench.sv
